// File: rtl/irx_pkg.sv
// Shared types, constants and helper functions of the image receiver.
`timescale 1ns / 1ps

package irx_pkg;

	localparam int SIZE_W      = 24;
	localparam int CRC_W       = 32;
	localparam int OFF_W       = 21;
	localparam int SECT_W      = 8;
	localparam int WORD_W      = 64;
	localparam int LANE_COUNT  = 16;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;
	localparam int FIFO_CNT_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [CRC_W-1:0]  CRC_POLY = 32'hEDB88320;
	localparam logic [7:0]        PAD_BYTE = 8'hFF;
	localparam logic [SECT_W-1:0] SECT_MAX = 8'd255;

	localparam logic REG_EXPECTED_SIZE = 1'b0;
	localparam logic REG_EXPECTED_CRC  = 1'b1;

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_DATA   = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_FAULT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_ERASE   = 2'd1,
		KIND_PROGRAM = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ERROR = 2'd1,
		ST_FLASH = 2'd2
	} status_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data_byte;
		logic       chunk_last;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		status_t            status;
		logic [OFF_W-1:0]   byte_offset;
		logic [SECT_W-1:0]  sector_count;
		logic [WORD_W-1:0]  word_low;
		logic [WORD_W-1:0]  word_high;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] expected_size;
		logic [CRC_W-1:0]  expected_crc;
	} cfg_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t  item0;
		out_item_t  item1;
	} push_t;

	function automatic out_item_t make_result(kind_t kind, status_t status,
			logic [OFF_W-1:0] offset, logic [SECT_W-1:0] sectors,
			logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
		out_item_t r;
		r.kind         = kind;
		r.status       = status;
		r.byte_offset  = offset;
		r.sector_count = sectors;
		r.word_low     = lo;
		r.word_high    = hi;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic out_item_t make_status(status_t status);
		return make_result(KIND_STATUS, status, '0, '0, '0, '0);
	endfunction

	// Reflected CRC-32 over one byte, with inversion on entry and exit.
	function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] crc, logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = ~crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		return ~c;
	endfunction

endpackage

// File: rtl/irx_stream_if.sv
// Valid/ready item channel with a typed payload.
`timescale 1ns / 1ps

interface irx_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/irx_proc.sv
// Input register, session state and per-item result formation.
`timescale 1ns / 1ps

module irx_proc #(
	parameter int MAX_IMAGE_BYTES = 1048576,
	parameter int SECTOR_BYTES    = 8192,
	parameter int WORD_BYTES      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	irx_stream_if.sink        image,
	input  irx_pkg::cfg_t     cfg,
	input  logic              room,
	output irx_pkg::push_t    push
);

	localparam int FILL_W     = $clog2(WORD_BYTES);
	localparam int DIV_W      = irx_pkg::SIZE_W + 1;
	localparam int RECIP_W    = DIV_W + 1;
	localparam int PROD_W     = DIV_W + RECIP_W;
	localparam int SECT_SHIFT = DIV_W + $clog2(SECTOR_BYTES);
	localparam longint unsigned SECT_RECIP =
		((64'd1 << SECT_SHIFT) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);

	logic                           valid_s1;
	irx_pkg::in_item_t              item_s1;
	logic                           fire;

	logic [irx_pkg::SIZE_W-1:0]     count_q, count_d;
	logic [irx_pkg::OFF_W-1:0]      offset_q, offset_d;
	logic [irx_pkg::CRC_W-1:0]      crc_q, crc_d;
	logic [FILL_W-1:0]              fill_q, fill_d;
	logic                           active_q, active_d;
	logic                           chunk_err_q, chunk_err_d;
	logic [7:0]                     buf_q [WORD_BYTES];
	logic                           buf_we;

	logic [8*WORD_BYTES-1:0]        word_bytes;
	logic [2*irx_pkg::WORD_W-1:0]   word_full;
	logic                           begin_ok;
	logic [DIV_W-1:0]               size_m1;
	logic [PROD_W-1:0]              prod;
	logic [irx_pkg::SECT_W-1:0]     sectors;

	assign fire        = valid_s1 && room;
	assign image.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image.valid && image.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (image.valid && image.ready) begin
			item_s1 <= image.data;
		end
	end

	// Sector count: the ceiling of size over sector size, saturated, by reciprocal multiplication.
	assign size_m1 = DIV_W'(cfg.expected_size) - DIV_W'(1);
	assign prod    = PROD_W'(size_m1) * PROD_W'(SECT_RECIP);
	assign sectors = (size_m1 >= DIV_W'(255 * SECTOR_BYTES)) ? irx_pkg::SECT_MAX
		: prod[SECT_SHIFT +: irx_pkg::SECT_W] + irx_pkg::SECT_W'(1);

	assign begin_ok = (cfg.expected_size != '0) &&
		(DIV_W'(cfg.expected_size) <= DIV_W'(MAX_IMAGE_BYTES));

	// Word lanes: stored bytes below the fill point, then the incoming byte or padding.
	always_comb begin
		for (int i = 0; i < WORD_BYTES; i++) begin
			if (FILL_W'(i) < fill_q) begin
				word_bytes[8*i +: 8] = buf_q[i];
			end else if (item_s1.action == irx_pkg::ACT_DATA) begin
				word_bytes[8*i +: 8] = item_s1.data_byte;
			end else begin
				word_bytes[8*i +: 8] = irx_pkg::PAD_BYTE;
			end
		end
		word_full = (2*irx_pkg::WORD_W)'(word_bytes);
	end

	always_comb begin
		irx_pkg::out_item_t r0;
		irx_pkg::out_item_t r1;
		irx_pkg::out_item_t prog;
		logic [1:0]         nres;

		count_d     = count_q;
		offset_d    = offset_q;
		crc_d       = crc_q;
		fill_d      = fill_q;
		active_d    = active_q;
		chunk_err_d = chunk_err_q;
		buf_we      = 1'b0;
		r0          = irx_pkg::make_status(irx_pkg::ST_OK);
		r1          = irx_pkg::make_status(irx_pkg::ST_OK);
		nres        = 2'd0;
		prog        = irx_pkg::make_result(irx_pkg::KIND_PROGRAM, irx_pkg::ST_OK, offset_q,
			'0, word_full[irx_pkg::WORD_W-1:0],
			word_full[2*irx_pkg::WORD_W-1:irx_pkg::WORD_W]);

		case (item_s1.action)
			irx_pkg::ACT_BEGIN: begin
				if (!begin_ok) begin
					r0 = irx_pkg::make_status(irx_pkg::ST_ERROR);
				end else begin
					count_d     = '0;
					offset_d    = '0;
					crc_d       = '0;
					fill_d      = '0;
					chunk_err_d = 1'b0;
					active_d    = 1'b1;
					r0 = irx_pkg::make_result(irx_pkg::KIND_ERASE, irx_pkg::ST_OK, '0,
						sectors, '0, '0);
				end
				nres = 2'd1;
			end
			irx_pkg::ACT_DATA: begin
				if (!active_q || (count_q >= cfg.expected_size)) begin
					chunk_err_d = 1'b1;
				end else begin
					crc_d   = irx_pkg::crc_byte(crc_q, item_s1.data_byte);
					count_d = count_q + irx_pkg::SIZE_W'(1);
					buf_we  = 1'b1;
					if (fill_q == FILL_W'(WORD_BYTES - 1)) begin
						r0       = prog;
						nres     = 2'd1;
						offset_d = offset_q + irx_pkg::OFF_W'(WORD_BYTES);
						fill_d   = '0;
					end else begin
						fill_d = fill_q + FILL_W'(1);
					end
				end
				if (item_s1.chunk_last) begin
					if (nres == 2'd0) begin
						r0 = irx_pkg::make_status(chunk_err_d ? irx_pkg::ST_ERROR
							: irx_pkg::ST_OK);
					end else begin
						r1 = irx_pkg::make_status(chunk_err_d ? irx_pkg::ST_ERROR
							: irx_pkg::ST_OK);
					end
					nres        = nres + 2'd1;
					chunk_err_d = 1'b0;
				end
			end
			irx_pkg::ACT_FINISH: begin
				if (!active_q) begin
					r0   = irx_pkg::make_status(irx_pkg::ST_ERROR);
					nres = 2'd1;
				end else begin
					if (fill_q != '0) begin
						r0       = prog;
						nres     = 2'd1;
						offset_d = offset_q + irx_pkg::OFF_W'(WORD_BYTES);
						fill_d   = '0;
					end
					active_d = 1'b0;
					if (nres == 2'd0) begin
						r0 = irx_pkg::make_status(((count_q == cfg.expected_size) &&
							(crc_q == cfg.expected_crc)) ? irx_pkg::ST_OK : irx_pkg::ST_ERROR);
					end else begin
						r1 = irx_pkg::make_status(((count_q == cfg.expected_size) &&
							(crc_q == cfg.expected_crc)) ? irx_pkg::ST_OK : irx_pkg::ST_ERROR);
					end
					nres = nres + 2'd1;
				end
			end
			irx_pkg::ACT_FAULT: begin
				active_d = 1'b0;
				r0       = irx_pkg::make_status(irx_pkg::ST_FLASH);
				nres     = 2'd1;
			end
			default: begin
				nres = 2'd0;
			end
		endcase

		if (nres == 2'd1) begin
			r0.last = 1'b1;
		end else if (nres == 2'd2) begin
			r1.last = 1'b1;
		end

		push.count = fire ? nres : 2'd0;
		push.item0 = r0;
		push.item1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			offset_q    <= '0;
			crc_q       <= '0;
			fill_q      <= '0;
			active_q    <= 1'b0;
			chunk_err_q <= 1'b0;
		end else if (fire) begin
			count_q     <= count_d;
			offset_q    <= offset_d;
			crc_q       <= crc_d;
			fill_q      <= fill_d;
			active_q    <= active_d;
			chunk_err_q <= chunk_err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && buf_we) begin
			buf_q[fill_q] <= item_s1.data_byte;
		end
	end

endmodule

// File: rtl/irx_out_fifo.sv
// Result queue that takes up to two items a cycle and hands out one.
`timescale 1ns / 1ps

module irx_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  irx_pkg::push_t  push,
	output logic            room,
	irx_stream_if.source    cmd
);

	irx_pkg::out_item_t                  mem [irx_pkg::FIFO_DEPTH];
	logic [irx_pkg::FIFO_PTR_W-1:0]      wptr_q;
	logic [irx_pkg::FIFO_PTR_W-1:0]      rptr_q;
	logic [irx_pkg::FIFO_CNT_W-1:0]      count_q;
	logic                                pop;

	assign pop       = cmd.valid && cmd.ready;
	assign room      = count_q <= irx_pkg::FIFO_CNT_W'(irx_pkg::FIFO_DEPTH - 2);
	assign cmd.valid = count_q != '0;
	assign cmd.data  = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + irx_pkg::FIFO_PTR_W'(push.count);
			rptr_q  <= rptr_q + irx_pkg::FIFO_PTR_W'(pop);
			count_q <= count_q + irx_pkg::FIFO_CNT_W'(push.count)
				- irx_pkg::FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wptr_q] <= push.item0;
		end
		if (push.count == 2'd2) begin
			mem[wptr_q + irx_pkg::FIFO_PTR_W'(1)] <= push.item1;
		end
	end

endmodule

// File: rtl/image_receiver_crc32_word_packer.sv
// Top level: configuration registers, item processing and result queue.
// An accepted item waits in the input register of irx_proc until the queue has room; its
// results are then written into the output queue, which offers them on cmd.
// Throughput: one item per cycle while each item gives one result and cmd.ready stays
// high; an item that gives two results (program word plus status) holds the output for both.
// The single result port of the output queue sets the rate.
// Reset (arst_n low, asynchronous) clears registers, session state and the queue.
`timescale 1ns / 1ps

module image_receiver_crc32_word_packer #(
	parameter int MAX_IMAGE_BYTES = 1048576,
	parameter int SECTOR_BYTES    = 8192,
	parameter int WORD_BYTES      = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	irx_stream_if.sink                         image,
	irx_stream_if.source                       cmd,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [irx_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [irx_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [irx_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	irx_pkg::cfg_t   cfg_q;
	irx_pkg::push_t  push;
	logic            room;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			if (paddr[2] == irx_pkg::REG_EXPECTED_SIZE) begin
				cfg_q.expected_size <= pwdata[irx_pkg::SIZE_W-1:0];
			end else begin
				cfg_q.expected_crc <= pwdata;
			end
		end
	end

	always_comb begin
		if (paddr[2] == irx_pkg::REG_EXPECTED_CRC) begin
			prdata = cfg_q.expected_crc;
		end else begin
			prdata = irx_pkg::APB_DATA_W'(cfg_q.expected_size);
		end
	end

	irx_proc #(
		.MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
		.SECTOR_BYTES    (SECTOR_BYTES),
		.WORD_BYTES      (WORD_BYTES)
	) u_proc (
		.clk    (clk),
		.arst_n (arst_n),
		.image  (image),
		.cfg    (cfg_q),
		.room   (room),
		.push   (push)
	);

	irx_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.cmd    (cmd)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("Results pushed without queue room.");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> (!push.item0.last && push.item1.last))
		else $error("Last flag misplaced on a result pair.");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |=> cmd.valid)
		else $error("Pushed result not offered on the output.");

	a_program_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.data.kind == irx_pkg::KIND_PROGRAM) |->
		(cmd.data.status == irx_pkg::ST_OK && cmd.data.sector_count == '0))
		else $error("Program command carries status or sector count.");

endmodule
